@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds whenever the antecedent holds.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// The expression is never true out of reset.
`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

@@ hw/rtl/rvr_pkg.sv @@
package rvr_pkg;

    localparam int DATA_W     = 16;
    // Bivector parts may be negated, so -32768 must become +32768.
    localparam int ROT_W      = DATA_W + 1;
    // Each first-layer product is at most 2^30 in magnitude.
    localparam int PROD1_W    = 32;
    localparam int INTER_W    = 33;
    // Each second-layer product stays below 2^47 in magnitude.
    localparam int PROD2_W    = 48;
    localparam int SUM_W      = 50;
    localparam int FRAC_SHIFT = 28;

    localparam logic CMD_FORWARD = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

    localparam logic signed [DATA_W-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] OUT_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [ROT_W-1:0] s;
        logic signed [ROT_W-1:0] b12;
        logic signed [ROT_W-1:0] b13;
        logic signed [ROT_W-1:0] b23;
    } rotor_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [INTER_W-1:0] e1;
        logic signed [INTER_W-1:0] e2;
        logic signed [INTER_W-1:0] e3;
        logic signed [INTER_W-1:0] e123;
    } inter_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } sum_t;

endpackage

@@ hw/rtl/rvr_intermediate.sv @@
module rvr_intermediate (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    input  rvr_pkg::rotor_t rotor,
    input  rvr_pkg::vec_t   vec,
    output logic            inter_valid,
    output rvr_pkg::rotor_t inter_rotor,
    output rvr_pkg::inter_t inter
);
    import rvr_pkg::*;

    typedef struct packed {
        logic signed [PROD1_W-1:0] sx;
        logic signed [PROD1_W-1:0] b12y;
        logic signed [PROD1_W-1:0] b13z;
        logic signed [PROD1_W-1:0] sy;
        logic signed [PROD1_W-1:0] b12x;
        logic signed [PROD1_W-1:0] b23z;
        logic signed [PROD1_W-1:0] sz;
        logic signed [PROD1_W-1:0] b13x;
        logic signed [PROD1_W-1:0] b23y;
        logic signed [PROD1_W-1:0] b12z;
        logic signed [PROD1_W-1:0] b13y;
        logic signed [PROD1_W-1:0] b23x;
    } prod1_t;

    function automatic logic signed [ROT_W-1:0] widen(input logic signed [DATA_W-1:0] v);
        return $signed({{(ROT_W-DATA_W){v[DATA_W-1]}}, v});
    endfunction

    function automatic logic signed [PROD1_W-1:0] mul1(input logic signed [ROT_W-1:0] a,
                                                        input logic signed [ROT_W-1:0] b);
        logic signed [2*ROT_W-1:0] full;
        full = a * b;
        return $signed(full[PROD1_W-1:0]);
    endfunction

    function automatic logic signed [INTER_W-1:0] ext1(input logic signed [PROD1_W-1:0] p);
        return $signed({{(INTER_W-PROD1_W){p[PROD1_W-1]}}, p});
    endfunction

    logic            prod_valid_reg;
    prod1_t          prod_reg;
    prod1_t          prod_next;
    rotor_t          prod_rotor_reg;
    logic            sum_valid_reg;
    inter_t          sum_reg;
    inter_t          sum_next;
    rotor_t          sum_rotor_reg;
    logic signed [ROT_W-1:0] vx;
    logic signed [ROT_W-1:0] vy;
    logic signed [ROT_W-1:0] vz;

    always_comb
    begin
        vx = widen(vec.x);
        vy = widen(vec.y);
        vz = widen(vec.z);
        prod_next.sx   = mul1(rotor.s, vx);
        prod_next.b12y = mul1(rotor.b12, vy);
        prod_next.b13z = mul1(rotor.b13, vz);
        prod_next.sy   = mul1(rotor.s, vy);
        prod_next.b12x = mul1(rotor.b12, vx);
        prod_next.b23z = mul1(rotor.b23, vz);
        prod_next.sz   = mul1(rotor.s, vz);
        prod_next.b13x = mul1(rotor.b13, vx);
        prod_next.b23y = mul1(rotor.b23, vy);
        prod_next.b12z = mul1(rotor.b12, vz);
        prod_next.b13y = mul1(rotor.b13, vy);
        prod_next.b23x = mul1(rotor.b23, vx);
    end

    // Vector and trivector parts of the left product, all exact.
    always_comb
    begin
        sum_next.e1   = ext1(prod_reg.sx) + ext1(prod_reg.b12y) + ext1(prod_reg.b13z);
        sum_next.e2   = ext1(prod_reg.sy) - ext1(prod_reg.b12x) + ext1(prod_reg.b23z);
        sum_next.e3   = ext1(prod_reg.sz) - ext1(prod_reg.b13x) - ext1(prod_reg.b23y);
        sum_next.e123 = ext1(prod_reg.b12z) - ext1(prod_reg.b13y) + ext1(prod_reg.b23x);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= valid;
            sum_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        prod_rotor_reg <= rotor;
        sum_reg        <= sum_next;
        sum_rotor_reg  <= prod_rotor_reg;
    end

    assign inter_valid = sum_valid_reg;
    assign inter_rotor = sum_rotor_reg;
    assign inter       = sum_reg;

endmodule

@@ hw/rtl/rvr_outer.sv @@
module rvr_outer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            inter_valid,
    input  rvr_pkg::rotor_t inter_rotor,
    input  rvr_pkg::inter_t inter,
    output logic            sum_valid,
    output rvr_pkg::sum_t   sum
);
    import rvr_pkg::*;

    typedef struct packed {
        logic signed [PROD2_W-1:0] s_e1;
        logic signed [PROD2_W-1:0] b12_e2;
        logic signed [PROD2_W-1:0] b13_e3;
        logic signed [PROD2_W-1:0] b23_e123;
        logic signed [PROD2_W-1:0] b12_e1;
        logic signed [PROD2_W-1:0] s_e2;
        logic signed [PROD2_W-1:0] b23_e3;
        logic signed [PROD2_W-1:0] b13_e123;
        logic signed [PROD2_W-1:0] b13_e1;
        logic signed [PROD2_W-1:0] b23_e2;
        logic signed [PROD2_W-1:0] s_e3;
        logic signed [PROD2_W-1:0] b12_e123;
    } prod2_t;

    function automatic logic signed [PROD2_W-1:0] mul2(input logic signed [ROT_W-1:0] a,
                                                        input logic signed [INTER_W-1:0] b);
        logic signed [ROT_W+INTER_W-1:0] full;
        full = a * b;
        return $signed(full[PROD2_W-1:0]);
    endfunction

    function automatic logic signed [SUM_W-1:0] ext2(input logic signed [PROD2_W-1:0] p);
        return $signed({{(SUM_W-PROD2_W){p[PROD2_W-1]}}, p});
    endfunction

    logic   prod_valid_reg;
    prod2_t prod_reg;
    prod2_t prod_next;
    logic   sum_valid_reg;
    sum_t   sum_reg;
    sum_t   sum_next;

    always_comb
    begin
        prod_next.s_e1     = mul2(inter_rotor.s, inter.e1);
        prod_next.b12_e2   = mul2(inter_rotor.b12, inter.e2);
        prod_next.b13_e3   = mul2(inter_rotor.b13, inter.e3);
        prod_next.b23_e123 = mul2(inter_rotor.b23, inter.e123);
        prod_next.b12_e1   = mul2(inter_rotor.b12, inter.e1);
        prod_next.s_e2     = mul2(inter_rotor.s, inter.e2);
        prod_next.b23_e3   = mul2(inter_rotor.b23, inter.e3);
        prod_next.b13_e123 = mul2(inter_rotor.b13, inter.e123);
        prod_next.b13_e1   = mul2(inter_rotor.b13, inter.e1);
        prod_next.b23_e2   = mul2(inter_rotor.b23, inter.e2);
        prod_next.s_e3     = mul2(inter_rotor.s, inter.e3);
        prod_next.b12_e123 = mul2(inter_rotor.b12, inter.e123);
    end

    // Right product with the reversed rotor; only the vector part survives.
    always_comb
    begin
        sum_next.x = ext2(prod_reg.s_e1) + ext2(prod_reg.b12_e2)
                   + ext2(prod_reg.b13_e3) + ext2(prod_reg.b23_e123);
        sum_next.y = ext2(prod_reg.s_e2) - ext2(prod_reg.b12_e1)
                   + ext2(prod_reg.b23_e3) - ext2(prod_reg.b13_e123);
        sum_next.z = ext2(prod_reg.s_e3) - ext2(prod_reg.b13_e1)
                   - ext2(prod_reg.b23_e2) + ext2(prod_reg.b12_e123);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= inter_valid;
            sum_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

endmodule

@@ hw/rtl/rvr_round_sat.sv @@
module rvr_round_sat (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sum_valid,
    input  rvr_pkg::sum_t                    sum,
    output logic                             done,
    output logic signed [rvr_pkg::DATA_W-1:0] out_x,
    output logic signed [rvr_pkg::DATA_W-1:0] out_y,
    output logic signed [rvr_pkg::DATA_W-1:0] out_z,
    output logic                             saturated
);
    import rvr_pkg::*;

    localparam int TOP_LSB = FRAC_SHIFT + DATA_W - 1;

    // Dropping the fraction bits of a two's complement value is a floor.
    // The result fits when every bit from the new sign bit upwards agrees.
    function automatic logic clips(input logic signed [SUM_W-1:0] v);
        return !((&v[SUM_W-1:TOP_LSB]) || !(|v[SUM_W-1:TOP_LSB]));
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (clips(v))
            r = v[SUM_W-1] ? OUT_MIN : OUT_MAX;
        else
            r = $signed(v[TOP_LSB:FRAC_SHIFT]);
        return r;
    endfunction

    logic                     done_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] y_reg;
    logic signed [DATA_W-1:0] z_reg;
    logic                     sat_reg;
    logic signed [DATA_W-1:0] x_next;
    logic signed [DATA_W-1:0] y_next;
    logic signed [DATA_W-1:0] z_next;
    logic                     sat_next;

    always_comb
    begin
        x_next   = clamp(sum.x);
        y_next   = clamp(sum.y);
        z_next   = clamp(sum.z);
        sat_next = clips(sum.x) || clips(sum.y) || clips(sum.z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sum_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        sat_reg <= sat_next;
    end

    assign done      = done_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign saturated = sat_reg;

endmodule

@@ hw/rtl/rotor_vector_rotate_unit.sv @@
// Fully pipelined rotor sandwich: one word may be started in every clock cycle.
// The result strobe done rises for each taken word once it leaves the output stage.
// Latency is set by the six register stages: input, two per product layer, output.
// busy is held low; the receiver cannot stall and nothing backs up.
// rst_n clears the valid bits asynchronously; data registers are not reset.
`include "assert_macros.svh"

module rotor_vector_rotate_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              command,
    input  logic signed [rvr_pkg::DATA_W-1:0] rotor_scalar,
    input  logic signed [rvr_pkg::DATA_W-1:0] rotor_b12,
    input  logic signed [rvr_pkg::DATA_W-1:0] rotor_b13,
    input  logic signed [rvr_pkg::DATA_W-1:0] rotor_b23,
    input  logic signed [rvr_pkg::DATA_W-1:0] vec_x,
    input  logic signed [rvr_pkg::DATA_W-1:0] vec_y,
    input  logic signed [rvr_pkg::DATA_W-1:0] vec_z,
    output logic                              done,
    output logic signed [rvr_pkg::DATA_W-1:0] out_x,
    output logic signed [rvr_pkg::DATA_W-1:0] out_y,
    output logic signed [rvr_pkg::DATA_W-1:0] out_z,
    output logic                              saturated
);
    import rvr_pkg::*;

    function automatic logic signed [ROT_W-1:0] widen(input logic signed [DATA_W-1:0] v);
        return $signed({{(ROT_W-DATA_W){v[DATA_W-1]}}, v});
    endfunction

    function automatic logic signed [ROT_W-1:0] orient(input logic signed [DATA_W-1:0] v,
                                                        input logic inv);
        return inv ? -widen(v) : widen(v);
    endfunction

    logic   accept;
    logic   in_valid_reg;
    rotor_t rotor_reg;
    rotor_t rotor_next;
    vec_t   vec_reg;
    vec_t   vec_next;
    logic   inter_valid;
    rotor_t inter_rotor;
    inter_t inter;
    logic   sum_valid;
    sum_t   sum;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // The inverse sandwich is the forward one with the bivector parts negated.
    always_comb
    begin
        rotor_next.s   = widen(rotor_scalar);
        rotor_next.b12 = orient(rotor_b12, command == CMD_INVERSE);
        rotor_next.b13 = orient(rotor_b13, command == CMD_INVERSE);
        rotor_next.b23 = orient(rotor_b23, command == CMD_INVERSE);
        vec_next.x     = vec_x;
        vec_next.y     = vec_y;
        vec_next.z     = vec_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        rotor_reg <= rotor_next;
        vec_reg   <= vec_next;
    end

    rvr_intermediate u_intermediate (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (in_valid_reg),
        .rotor       (rotor_reg),
        .vec         (vec_reg),
        .inter_valid (inter_valid),
        .inter_rotor (inter_rotor),
        .inter       (inter)
    );

    rvr_outer u_outer (
        .clk         (clk),
        .rst_n       (rst_n),
        .inter_valid (inter_valid),
        .inter_rotor (inter_rotor),
        .inter       (inter),
        .sum_valid   (sum_valid),
        .sum         (sum)
    );

    rvr_round_sat u_round_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum       (sum),
        .done      (done),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .saturated (saturated)
    );

    `ASSERT_IMPLIES(a_word_completes, accept, ##6 done)
    `ASSERT_NEVER(a_no_spurious_done, done && !$past(accept, 6))
    `ASSERT_IMPLIES(a_sat_at_limit, done && saturated,
        out_x == OUT_MAX || out_x == OUT_MIN || out_y == OUT_MAX ||
        out_y == OUT_MIN || out_z == OUT_MAX || out_z == OUT_MIN)

endmodule

@@ tb/rotor_vector_rotate_unit_test.sv @@
module rotor_vector_rotate_unit_test;

    import rvr_pkg::*;

    localparam int CYCLE_LIMIT  = 60000;
    localparam int RANDOM_WORDS = 900;
    localparam int TAIL_CYCLES  = 12;

    typedef logic signed [DATA_W-1:0] word16_t;

    typedef struct {
        word16_t x;
        word16_t y;
        word16_t z;
        logic    sat;
    } rotated_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    command;
    word16_t rotor_scalar;
    word16_t rotor_b12;
    word16_t rotor_b13;
    word16_t rotor_b23;
    word16_t vec_x;
    word16_t vec_y;
    word16_t vec_z;
    logic    done;
    word16_t out_x;
    word16_t out_y;
    word16_t out_z;
    logic    saturated;

    rotated_t    pending_rotations[$];
    rotated_t    oldest_rotation;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned words_sent;
    int unsigned results_checked;
    int unsigned clipped_results;
    bit          back_to_back;

    rotor_vector_rotate_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .rotor_scalar (rotor_scalar),
        .rotor_b12    (rotor_b12),
        .rotor_b13    (rotor_b13),
        .rotor_b23    (rotor_b23),
        .vec_x        (vec_x),
        .vec_y        (vec_y),
        .vec_z        (vec_z),
        .done         (done),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .saturated    (saturated)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_rotations.size());
            $display("rotor_vector_rotate_unit_test failed");
            $finish;
        end
    end

    // Floor by 2^28, then clip to the signed 16-bit range.
    function automatic word16_t clamp_component(input longint full, inout logic clipped);
        longint q;
        q = full >>> FRAC_SHIFT;
        if (q > longint'(OUT_MAX))
        begin
            q = longint'(OUT_MAX);
            clipped = 1'b1;
        end
        if (q < longint'(OUT_MIN))
        begin
            q = longint'(OUT_MIN);
            clipped = 1'b1;
        end
        return q[DATA_W-1:0];
    endfunction

    function automatic rotated_t predict_rotation(input logic cmd, input word16_t s_in,
                                                  input word16_t b12_in, input word16_t b13_in,
                                                  input word16_t b23_in, input word16_t vx,
                                                  input word16_t vy, input word16_t vz);
        longint   s;
        longint   p12;
        longint   p13;
        longint   p23;
        longint   a;
        longint   b;
        longint   c;
        longint   t1;
        longint   t2;
        longint   t3;
        longint   t123;
        logic     clipped;
        rotated_t r;
        s   = s_in;
        p12 = b12_in;
        p13 = b13_in;
        p23 = b23_in;
        a   = vx;
        b   = vy;
        c   = vz;
        // The inverse sandwich is the forward one with the bivector negated.
        if (cmd == CMD_INVERSE)
        begin
            p12 = -p12;
            p13 = -p13;
            p23 = -p23;
        end
        t1   = s * a + p12 * b + p13 * c;
        t2   = s * b - p12 * a + p23 * c;
        t3   = s * c - p13 * a - p23 * b;
        t123 = p12 * c - p13 * b + p23 * a;
        clipped = 1'b0;
        r.x = clamp_component(s * t1 + p12 * t2 + p13 * t3 + p23 * t123, clipped);
        r.y = clamp_component(-p12 * t1 + s * t2 + p23 * t3 - p13 * t123, clipped);
        r.z = clamp_component(-p13 * t1 - p23 * t2 + s * t3 + p12 * t123, clipped);
        r.sat = clipped;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s; got x=%0d y=%0d z=%0d sat=%0b", $time, what,
                     out_x, out_y, out_z, saturated);
    endtask

    // A result is on the ports for one cycle only, so it is taken at the edge ending it.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_rotations.size() == 0)
                report_mismatch("result with no word outstanding");
            else
            begin
                oldest_rotation = pending_rotations.pop_front();
                results_checked++;
                if (oldest_rotation.sat)
                    clipped_results++;
                if (out_x !== oldest_rotation.x || out_y !== oldest_rotation.y ||
                    out_z !== oldest_rotation.z || saturated !== oldest_rotation.sat)
                    report_mismatch($sformatf("wrong result, expected x=%0d y=%0d z=%0d sat=%0b",
                                              oldest_rotation.x, oldest_rotation.y,
                                              oldest_rotation.z, oldest_rotation.sat));
            end
        end
    end

    task automatic send_rotation(input logic cmd, input word16_t s_in, input word16_t b12_in,
                                 input word16_t b13_in, input word16_t b23_in,
                                 input word16_t vx, input word16_t vy, input word16_t vz);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        command      <= cmd;
        rotor_scalar <= s_in;
        rotor_b12    <= b12_in;
        rotor_b13    <= b13_in;
        rotor_b23    <= b23_in;
        vec_x        <= vx;
        vec_y        <= vy;
        vec_z        <= vz;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pending_rotations.push_back(predict_rotation(cmd, s_in, b12_in, b13_in, b23_in,
                                                     vx, vy, vz));
        words_sent++;
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_rotations.size() != 0)
            @(posedge clk);
    endtask

    function automatic word16_t random_rotor_part();
        if ($urandom_range(0, 3) == 0)
            return word16_t'($urandom());
        return word16_t'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic word16_t random_vector_part();
        case ($urandom_range(0, 9))
            0: return OUT_MAX;
            1: return OUT_MIN;
            2: return word16_t'(int'($urandom_range(0, 2)) - 1);
            default: return word16_t'($urandom());
        endcase
    endfunction

    task automatic test_identity_rotor();
        send_rotation(CMD_FORWARD, 16384, 0, 0, 0, 32767, -32768, 0);
        send_rotation(CMD_INVERSE, 16384, 0, 0, 0, -1, 1, -32768);
        send_rotation(CMD_FORWARD, 16384, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_quarter_turns();
        send_rotation(CMD_FORWARD, 11585, 11585, 0, 0, 10000, 0, 0);
        send_rotation(CMD_INVERSE, 11585, 11585, 0, 0, 10000, 0, 0);
        send_rotation(CMD_FORWARD, 11585, 0, 11585, 0, 0, 20000, -20000);
        send_rotation(CMD_INVERSE, 11585, 0, 0, 11585, -32768, 32767, 1);
    endtask

    task automatic test_half_turns();
        send_rotation(CMD_FORWARD, 0, 16384, 0, 0, 1000, 2000, 3000);
        send_rotation(CMD_INVERSE, 0, 0, -16384, 0, -1000, 2000, -3000);
        // The half turn negates y and z, and -32768 overflows 16 bits, so this one must clip.
        send_rotation(CMD_FORWARD, 0, 0, 0, 16384, -32768, -32768, -32768);
    endtask

    task automatic test_rotor_extremes();
        send_rotation(CMD_FORWARD, -32768, -32768, -32768, -32768, 32767, 32767, 32767);
        send_rotation(CMD_INVERSE, -32768, -32768, -32768, -32768, -32768, 32767, -32768);
        send_rotation(CMD_FORWARD, 32767, -32768, 32767, -32768, 32767, -32768, 1);
        send_rotation(CMD_INVERSE, 32767, 32767, 32767, 32767, -1, -1, -1);
    endtask

    task automatic test_scaling_and_flooring();
        // A tiny rotor leaves a small negative value, which must floor to -1.
        send_rotation(CMD_FORWARD, 1, 0, 0, 0, -1, 1, -32768);
        send_rotation(CMD_INVERSE, 0, 0, 0, 0, 32767, -32768, 12345);
        // A squared norm of about two doubles the vector and clips the larger parts.
        send_rotation(CMD_FORWARD, 23170, 0, 0, 0, 20000, -20000, 100);
        send_rotation(CMD_INVERSE, 8192, 0, 8192, 0, 32767, 32767, -32768);
    endtask

    task automatic test_random_rotations(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                back_to_back = ($urandom_range(0, 2) == 0);
            send_rotation(logic'($urandom_range(0, 1)), random_rotor_part(),
                          random_rotor_part(), random_rotor_part(), random_rotor_part(),
                          random_vector_part(), random_vector_part(), random_vector_part());
        end
        back_to_back = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        wait_for_results();
        send_rotation(CMD_FORWARD, 11585, 0, 0, -11585, 4096, -4096, 30000);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        command         = CMD_FORWARD;
        rotor_scalar    = '0;
        rotor_b12       = '0;
        rotor_b13       = '0;
        rotor_b23       = '0;
        vec_x           = '0;
        vec_y           = '0;
        vec_z           = '0;
        cycle_count     = 0;
        mismatch_count  = 0;
        words_sent      = 0;
        results_checked = 0;
        clipped_results = 0;
        back_to_back    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_identity_rotor();
        test_quarter_turns();
        test_half_turns();
        test_rotor_extremes();
        test_scaling_and_flooring();
        test_random_rotations(RANDOM_WORDS / 2);
        test_pause_until_drained();
        test_random_rotations(RANDOM_WORDS / 2);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d rotation words in both directions, unit and arbitrary rotors.",
                 words_sent);
        $display("Checked %0d results, %0d of them clipped; %0d mismatches.",
                 results_checked, clipped_results, mismatch_count);
        if (mismatch_count == 0)
            $display("rotor_vector_rotate_unit_test passed");
        else
            $display("rotor_vector_rotate_unit_test failed");
        $finish;
    end

endmodule
